/* design/hsfr_pkg.sv */
// ============================================================================
// hsfr_pkg
// Shared types, constants and helper functions of the serial frame receiver.
// ============================================================================
`default_nettype none

package hsfr_pkg;

    localparam int BufDepth = 64;
    localparam int CntW     = $clog2(BufDepth + 1);
    localparam int AddrW    = $clog2(BufDepth);

    localparam logic [7:0] TAIL_FF  = 8'hFF;
    localparam logic [7:0] TAIL_01  = 8'h01;
    localparam logic [7:0] TAIL_FE  = 8'hFE;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [2:0] CFG_USE_END_MARKERS = 3'd0;
    localparam logic [2:0] CFG_HEADER_LENGTH   = 3'd1;
    localparam logic [2:0] CFG_HEADER_BYTES    = 3'd2;
    localparam logic [2:0] CFG_TAIL_LENGTH     = 3'd3;
    localparam logic [2:0] CFG_TAIL_BYTES      = 3'd4;

    typedef enum logic [1:0] {
        KIND_READY = 2'd0,
        KIND_OVF   = 2'd1,
        KIND_FRAME = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t           kind;
        logic [CntW-1:0] len;
    } cmd_t;

    typedef struct packed {
        logic             en;
        logic [AddrW-1:0] addr;
        logic [7:0]       data;
    } mem_wr_t;

    function automatic logic [2:0] clamp4(input logic [2:0] v);
        return (v > 3'd4) ? 3'd4 : v;
    endfunction

    function automatic logic [7:0] byte_of(input logic [31:0] w, input logic [1:0] i);
        return w[8*i +: 8];
    endfunction

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // w[0] holds the newest byte
    function automatic logic tail_hit(input logic [3:0][7:0] w, input logic [31:0] tail,
                                      input logic [2:0] len);
        logic hit;
        hit = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < len) begin
                if (w[2'(len - 3'(i) - 3'd1)] != byte_of(tail, 2'(i))) begin
                    hit = 1'b0;
                end
            end
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

/* design/hsfr_front.sv */
// ============================================================================
// hsfr_front
// Byte intake: header match, payload store, tail and CRC detection.
// ============================================================================
`default_nettype none

module hsfr_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             rx_byte,
    input  wire logic                   cfg_valid,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [31:0]            cfg_data,
    input  wire logic                   fifo_full,
    input  wire logic                   frame_done,
    output logic                        push_valid,
    output hsfr_pkg::cmd_t              push_cmd,
    output hsfr_pkg::mem_wr_t           mem_wr
);

    typedef enum logic [4:0] {
        PH_INIT  = 5'b00001,
        PH_IDLE  = 5'b00010,
        PH_HEAD  = 5'b00100,
        PH_RCV   = 5'b01000,
        PH_ERROR = 5'b10000
    } phase_t;

    phase_t                       phase_reg, phase_next;
    logic [hsfr_pkg::CntW-1:0]    cnt_reg, cnt_next, cnt_inc;
    logic [3:0][7:0]              win_reg, win_next, win_sh;
    logic [3:0][15:0]             crc_reg, crc_next;
    logic                         frame_out_reg, frame_out_next;
    logic                         use_end_reg;
    logic [2:0]                   hlen_reg, tlen_reg, hlen, tlen;
    logic [31:0]                  hdr_reg, tail_reg;
    logic                         accept, ff_hit, crc_hit, cust_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_end_reg <= 1'b1;
            hlen_reg    <= '0;
            hdr_reg     <= '0;
            tlen_reg    <= '0;
            tail_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                hsfr_pkg::CFG_USE_END_MARKERS: use_end_reg <= cfg_data[0];
                hsfr_pkg::CFG_HEADER_LENGTH:   hlen_reg    <= cfg_data[2:0];
                hsfr_pkg::CFG_HEADER_BYTES:    hdr_reg     <= cfg_data;
                hsfr_pkg::CFG_TAIL_LENGTH:     tlen_reg    <= cfg_data[2:0];
                hsfr_pkg::CFG_TAIL_BYTES:      tail_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign hlen     = hsfr_pkg::clamp4(hlen_reg);
    assign tlen     = hsfr_pkg::clamp4(tlen_reg);
    assign in_ready = !fifo_full && !frame_out_reg;
    assign accept   = in_valid && in_ready;
    assign cnt_inc  = cnt_reg + 1'b1;
    assign win_sh   = {win_reg[2:0], rx_byte};

    assign ff_hit   = (cnt_inc >= hsfr_pkg::CntW'(3)) && win_sh[0] == hsfr_pkg::TAIL_FF
                      && win_sh[1] == hsfr_pkg::TAIL_FF && win_sh[2] == hsfr_pkg::TAIL_FF;
    assign crc_hit  = (cnt_inc >= hsfr_pkg::CntW'(4)) && win_sh[3] == hsfr_pkg::TAIL_01
                      && win_sh[2] == hsfr_pkg::TAIL_FE && win_sh[1] == hsfr_pkg::TAIL_FE
                      && win_sh[0] == hsfr_pkg::TAIL_FE;
    assign cust_hit = (tlen != 3'd0) && (cnt_inc >= hsfr_pkg::CntW'(tlen))
                      && hsfr_pkg::tail_hit(win_sh, tail_reg, tlen);

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        win_next   = win_reg;
        crc_next   = crc_reg;
        mem_wr     = '0;
        push_valid = 1'b0;
        push_cmd   = '{kind: hsfr_pkg::KIND_READY, len: '0};
        if (accept)
        begin
            case (phase_reg)
                PH_INIT:
                begin
                    phase_next = PH_IDLE;
                    push_valid = 1'b1;
                end
                PH_IDLE, PH_ERROR:
                begin
                    cnt_next = '0;
                    if (hlen == 3'd0)
                    begin
                        mem_wr      = '{en: 1'b1, addr: '0, data: rx_byte};
                        cnt_next    = hsfr_pkg::CntW'(1);
                        win_next    = win_sh;
                        crc_next[0] = hsfr_pkg::crc16_byte(hsfr_pkg::CRC_INIT, rx_byte);
                        phase_next  = PH_RCV;
                    end
                    else if (rx_byte == hsfr_pkg::byte_of(hdr_reg, 2'd0))
                    begin
                        if (hlen == 3'd1)
                        begin
                            crc_next[0] = hsfr_pkg::CRC_INIT;
                            phase_next  = PH_RCV;
                        end
                        else
                        begin
                            mem_wr     = '{en: 1'b1, addr: '0, data: rx_byte};
                            cnt_next   = hsfr_pkg::CntW'(1);
                            phase_next = PH_HEAD;
                        end
                    end
                end
                PH_HEAD:
                begin
                    if (cnt_reg >= hsfr_pkg::CntW'(hsfr_pkg::BufDepth))
                    begin
                        phase_next = PH_ERROR;
                        push_valid = 1'b1;
                        push_cmd   = '{kind: hsfr_pkg::KIND_OVF, len: '0};
                    end
                    else if (cnt_reg >= hsfr_pkg::CntW'(hlen)
                             || rx_byte != hsfr_pkg::byte_of(hdr_reg, cnt_reg[1:0]))
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        mem_wr   = '{en: 1'b1, addr: cnt_reg[hsfr_pkg::AddrW-1:0],
                                     data: rx_byte};
                        cnt_next = cnt_inc;
                        if (cnt_inc == hsfr_pkg::CntW'(hlen))
                        begin
                            cnt_next    = '0;
                            crc_next[0] = hsfr_pkg::CRC_INIT;
                            phase_next  = PH_RCV;
                        end
                    end
                end
                PH_RCV:
                begin
                    if (cnt_reg >= hsfr_pkg::CntW'(hsfr_pkg::BufDepth))
                    begin
                        phase_next = PH_ERROR;
                        push_valid = 1'b1;
                        push_cmd   = '{kind: hsfr_pkg::KIND_OVF, len: '0};
                    end
                    else
                    begin
                        mem_wr      = '{en: 1'b1, addr: cnt_reg[hsfr_pkg::AddrW-1:0],
                                        data: rx_byte};
                        cnt_next    = cnt_inc;
                        win_next    = win_sh;
                        crc_next[0] = hsfr_pkg::crc16_byte(crc_reg[0], rx_byte);
                        crc_next[3:1] = crc_reg[2:0];
                        if (use_end_reg)
                        begin
                            if (ff_hit)
                            begin
                                phase_next = PH_IDLE;
                                push_cmd   = '{kind: hsfr_pkg::KIND_FRAME,
                                               len: cnt_inc - hsfr_pkg::CntW'(3)};
                                push_valid = (push_cmd.len != '0);
                            end
                            else if (crc_hit)
                            begin
                                phase_next = PH_IDLE;
                                push_cmd   = '{kind: hsfr_pkg::KIND_FRAME,
                                               len: cnt_inc - hsfr_pkg::CntW'(4)};
                                push_valid = (push_cmd.len != '0) && (crc_reg[3] == '0);
                            end
                            else if (cust_hit)
                            begin
                                phase_next = PH_IDLE;
                                push_cmd   = '{kind: hsfr_pkg::KIND_FRAME,
                                               len: cnt_inc - hsfr_pkg::CntW'(tlen)};
                                push_valid = (push_cmd.len != '0);
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        frame_out_next = frame_out_reg;
        if (frame_done)
        begin
            frame_out_next = 1'b0;
        end
        if (push_valid && push_cmd.kind == hsfr_pkg::KIND_FRAME)
        begin
            frame_out_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_INIT;
            cnt_reg       <= '0;
            frame_out_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            frame_out_reg <= frame_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        crc_reg <= crc_next;
    end

endmodule

`default_nettype wire

/* design/hsfr_cmd_fifo.sv */
// ============================================================================
// hsfr_cmd_fifo
// Two-entry request queue between intake and emission.
// ============================================================================
`default_nettype none

module hsfr_cmd_fifo (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire hsfr_pkg::cmd_t         push_cmd,
    output logic                        full,
    input  wire logic                   pop,
    output logic                        not_empty,
    output hsfr_pkg::cmd_t              head
);

    hsfr_pkg::cmd_t entry_reg [2];
    logic           wp_reg, rp_reg;
    logic [1:0]     fill_reg;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign head      = entry_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wp_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* design/hsfr_back.sv */
// ============================================================================
// hsfr_back
// Frame store and result emission: events and payload bytes in order.
// ============================================================================
`default_nettype none

module hsfr_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire hsfr_pkg::mem_wr_t      mem_wr,
    input  wire logic                   cmd_valid,
    input  wire hsfr_pkg::cmd_t         cmd,
    output logic                        cmd_pop,
    output logic                        frame_done,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [1:0]                  event_kind,
    output logic [7:0]                  payload_byte,
    output logic                        frame_last
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_LD   = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    logic [7:0]                 mem [hsfr_pkg::BufDepth];
    logic [7:0]                 rd_data_reg;
    state_t                     state_reg, state_next;
    logic [hsfr_pkg::CntW-1:0]  idx_reg, idx_next, len_reg, len_next;
    logic                       valid_reg, valid_next, last_reg, last_next;
    logic                       is_frame_reg, is_frame_next;
    logic [1:0]                 kind_reg, kind_next;
    logic [7:0]                 byte_reg, byte_next;

    always_ff @(posedge clk)
    begin
        if (mem_wr.en)
        begin
            mem[mem_wr.addr] <= mem_wr.data;
        end
        rd_data_reg <= mem[idx_reg[hsfr_pkg::AddrW-1:0]];
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        len_next      = len_reg;
        valid_next    = valid_reg;
        last_next     = last_reg;
        is_frame_next = is_frame_reg;
        kind_next     = kind_reg;
        byte_next     = byte_reg;
        cmd_pop       = 1'b0;
        frame_done    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop       = 1'b1;
                    is_frame_next = (cmd.kind == hsfr_pkg::KIND_FRAME);
                    if (cmd.kind == hsfr_pkg::KIND_FRAME)
                    begin
                        idx_next   = '0;
                        len_next   = cmd.len;
                        state_next = S_RD;
                    end
                    else
                    begin
                        kind_next  = cmd.kind;
                        byte_next  = '0;
                        last_next  = 1'b1;
                        valid_next = 1'b1;
                        state_next = S_OUT;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_LD;
            end
            S_LD:
            begin
                kind_next  = hsfr_pkg::KIND_FRAME;
                byte_next  = rd_data_reg;
                last_next  = (idx_reg + 1'b1 == len_reg);
                valid_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    valid_next = 1'b0;
                    state_next = S_IDLE;
                    if (is_frame_reg && !last_reg)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RD;
                    end
                    else if (is_frame_reg)
                    begin
                        frame_done = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= 1'b0;
            idx_reg      <= '0;
            len_reg      <= '0;
            is_frame_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            idx_reg      <= idx_next;
            len_reg      <= len_next;
            is_frame_reg <= is_frame_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign out_valid    = valid_reg;
    assign event_kind   = kind_reg;
    assign payload_byte = byte_reg;
    assign frame_last   = last_reg;

`ifndef ASSERT_OFF
    a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg == (state_reg == S_OUT))
        else $error("result valid outside output state");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("emission state not one-hot");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |-> (last_reg && kind_reg == hsfr_pkg::KIND_FRAME))
        else $error("frame finished on a non-final byte");

    a_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg != hsfr_pkg::KIND_FRAME) |-> (byte_reg == '0 && last_reg))
        else $error("event result carries payload");
`endif

endmodule

`default_nettype wire

/* design/hmi_serial_frame_receiver.sv */
// ============================================================================
// hmi_serial_frame_receiver
// Serial byte deframer with header match, tail detection and CRC-16 check.
// ============================================================================
// Each received byte is taken by the intake stage, which matches the header,
// stores payload and spots a tail; results go through a two-entry request
// queue to the emission stage. A ready or overflow event is written into the
// queue and then registered at the output by the emission stage. The first
// payload byte of a frame is presented after the read and load steps, and each
// further byte passes through read, load and present in turn. Intake stalls
// while the queue is full and while a frame is being emitted, and resumes the
// cycle after its last byte is handed over.
`default_nettype none

module hmi_serial_frame_receiver (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       event_kind,
    output logic [7:0]       payload_byte,
    output logic             frame_last
);

    hsfr_pkg::cmd_t     push_cmd, head_cmd;
    hsfr_pkg::mem_wr_t  mem_wr;
    logic               push_valid, fifo_full, fifo_ne, cmd_pop, frame_done;

    assign cfg_ready = 1'b1;

    hsfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fifo_full  (fifo_full),
        .frame_done (frame_done),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .mem_wr     (mem_wr)
    );

    hsfr_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_cmd   (push_cmd),
        .full       (fifo_full),
        .pop        (cmd_pop),
        .not_empty  (fifo_ne),
        .head       (head_cmd)
    );

    hsfr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .mem_wr       (mem_wr),
        .cmd_valid    (fifo_ne),
        .cmd          (head_cmd),
        .cmd_pop      (cmd_pop),
        .frame_done   (frame_done),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_kind   (event_kind),
        .payload_byte (payload_byte),
        .frame_last   (frame_last)
    );

endmodule

`default_nettype wire
